// ----- sv/adam_pkg.sv -----
// ----------------------------------------------------------------------------
// Adam optimiser package
// Shared types, register map, status codes and step counts for the Adam
// parameter update block.
// ----------------------------------------------------------------------------
package adam_pkg;

  // APB address width: five registers at word spacing.
  localparam int APB_AW = 5;

  // Register indexes, taken from paddr[4:2].
  localparam logic [2:0] REG_BETA_FIRST    = 3'd0;
  localparam logic [2:0] REG_BETA_SECOND   = 3'd1;
  localparam logic [2:0] REG_STABILIZER    = 3'd2;
  localparam logic [2:0] REG_LEARNING_RATE = 3'd3;
  localparam logic [2:0] REG_ELEMENT_COUNT = 3'd4;

  // Register reset values.
  localparam logic [15:0] BETA_FIRST_RST    = 16'd44564;
  localparam logic [15:0] BETA_SECOND_RST   = 16'd52429;
  localparam logic [31:0] STABILIZER_RST    = 32'd429497;
  localparam logic [31:0] LEARNING_RATE_RST = 32'd4294967;
  localparam logic [10:0] ELEMENT_COUNT_RST = 11'd1024;

  // One in Q0.32, saturated.
  localparam logic [31:0] ONE_Q32 = 32'hFFFF_FFFF;

  // Result status codes.
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_RANGE   = 2'd1;
  localparam logic [1:0] STATUS_CLEARED = 2'd2;

  // Item operation codes.
  localparam logic OPC_UPDATE = 1'b0;
  localparam logic OPC_CLEAR  = 1'b1;

  // Iteration counts of the shared divider and the square root unit.
  localparam int DIV_STEPS  = 64;
  localparam int SQRT_STEPS = 32;

  typedef struct packed {
    logic [15:0] beta_first;
    logic [15:0] beta_second;
    logic [31:0] stabilizer;
    logic [31:0] learning_rate;
    logic [10:0] element_count;
  } cfg_t;

  // Controller states.
  typedef enum logic [4:0] {
    S_SWEEP_RST,
    S_IDLE,
    S_DECIDE,
    S_CLEAR,
    S_MUL_BFP,
    S_MUL_BSP,
    S_MUL_M1,
    S_MUL_M2,
    S_MUL_G2,
    S_MUL_V1,
    S_MUL_V2,
    S_UPD,
    S_DIVM_INIT,
    S_DIVM,
    S_DIVV_INIT,
    S_DIVV,
    S_SQRT_INIT,
    S_SQRT,
    S_MUL_STEP,
    S_DIVS_INIT,
    S_DIVS,
    S_OUT
  } ctrl_state_t;

  // Datapath operations.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SWEEP,
    OP_MUL_BFP,
    OP_MUL_BSP,
    OP_MUL_M1,
    OP_MUL_M2,
    OP_MUL_G2,
    OP_MUL_V1,
    OP_MUL_V2,
    OP_DIVM_INIT,
    OP_DIVV_INIT,
    OP_DIV_STEP,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_MUL_STEP,
    OP_DIVS_INIT,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic out_of_range;
    logic step_start;
  } dp_status_t;

endpackage

// ----- sv/adam_ifs.sv -----
// ----------------------------------------------------------------------------
// Adam optimiser channel interfaces
// Valid/ready channels for input items and for results.
// ----------------------------------------------------------------------------
interface adam_item_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [9:0]  element_index;
  logic        step_start;
  logic [31:0] gradient;
  logic [31:0] param_in;

  modport source (output valid, op, element_index, step_start, gradient, param_in,
                  input ready);
  modport sink (input valid, op, element_index, step_start, gradient, param_in,
                output ready);
endinterface

interface adam_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] param_out;
  logic [9:0]  index_out;
  logic [1:0]  status;

  modport source (output valid, param_out, index_out, status, input ready);
  modport sink (input valid, param_out, index_out, status, output ready);
endinterface

// ----- sv/adam_optimizer_update.sv -----
// ----------------------------------------------------------------------------
// Adam optimiser parameter update
// Top level: APB registers, sequencing controller and fixed-point datapath.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake        Beat contents
//   item      in         valid/ready      op, element_index, step_start,
//                                         gradient, param_in
//   result    out        valid/ready      param_out, index_out, status
//   apb       in/out     psel/penable     register write and read-back
//
// An update item runs the shared restoring divider for 64 one-bit steps in
// each of its three divisions and the square root unit for 32 steps; a
// step_start item first updates the beta powers. Cleared and out-of-range
// items skip the arithmetic; a clear item adds a sweep over every entry.
// After reset the stores are swept over every entry with ready low.
// A waiting result holds in the output register while the next item is
// accepted; the block stalls only when a second result is ready to leave.
// ----------------------------------------------------------------------------
module adam_optimizer_update #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  adam_item_if.sink                   item,
  adam_result_if.source               result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [adam_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import adam_pkg::*;

  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

  cfg_t          cfg;
  dp_cmd_t       cmd;
  dp_status_t    dp_stat;
  logic [AW-1:0] sweep_addr;

  // Configuration registers.
  adam_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencing controller.
  adam_ctrl #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .AW           (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .status     (dp_stat),
    .cmd        (cmd),
    .sweep_addr (sweep_addr)
  );

  // Arithmetic and stores.
  adam_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .AW           (AW)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .cmd              (cmd),
    .sweep_addr       (sweep_addr),
    .in_op            (item.op),
    .in_element_index (item.element_index),
    .in_step_start    (item.step_start),
    .in_gradient      (item.gradient),
    .in_param_in      (item.param_in),
    .status           (dp_stat),
    .param_out        (result.param_out),
    .index_out        (result.index_out),
    .res_status       (result.status)
  );

`ifndef SYNTHESIS
  // Only one item is in flight: ready drops right after an accepted beat.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> !item.ready)
    else $error("item accepted while another is being processed");

  // A new result appears only while no item can be taken.
  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(!item.ready))
    else $error("result produced while idle");

  // Status carries one of the three defined codes.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.status == STATUS_OK || result.status == STATUS_RANGE ||
                      result.status == STATUS_CLEARED))
    else $error("undefined result status");
`endif

endmodule

// ----- sv/adam_regs.sv -----
// ----------------------------------------------------------------------------
// Adam optimiser configuration registers
// APB register file holding the decay rates, epsilon, eta and element count.
// ----------------------------------------------------------------------------
module adam_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [adam_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output adam_pkg::cfg_t              cfg
);
  import adam_pkg::*;

  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.beta_first    <= BETA_FIRST_RST;
      cfg.beta_second   <= BETA_SECOND_RST;
      cfg.stabilizer    <= STABILIZER_RST;
      cfg.learning_rate <= LEARNING_RATE_RST;
      cfg.element_count <= ELEMENT_COUNT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_BETA_FIRST:    cfg.beta_first    <= pwdata[15:0];
        REG_BETA_SECOND:   cfg.beta_second   <= pwdata[15:0];
        REG_STABILIZER:    cfg.stabilizer    <= pwdata;
        REG_LEARNING_RATE: cfg.learning_rate <= pwdata;
        REG_ELEMENT_COUNT: cfg.element_count <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  // Read-back multiplexer.
  always_comb begin
    case (reg_idx)
      REG_BETA_FIRST:    prdata = {16'd0, cfg.beta_first};
      REG_BETA_SECOND:   prdata = {16'd0, cfg.beta_second};
      REG_STABILIZER:    prdata = cfg.stabilizer;
      REG_LEARNING_RATE: prdata = cfg.learning_rate;
      REG_ELEMENT_COUNT: prdata = {21'd0, cfg.element_count};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

// ----- sv/adam_ctrl.sv -----
// ----------------------------------------------------------------------------
// Adam optimiser controller
// State machine that sequences the multiplier, divider and square root steps
// of the datapath, runs the store clearing sweeps and owns the handshakes.
// ----------------------------------------------------------------------------
module adam_ctrl #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int AW           = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  adam_pkg::dp_status_t status,
  output adam_pkg::dp_cmd_t    cmd,
  output logic [AW-1:0]        sweep_addr
);
  import adam_pkg::*;

  localparam int CW = $clog2(MAX_ELEMENTS > DIV_STEPS ? MAX_ELEMENTS : DIV_STEPS);

  ctrl_state_t   state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic          counting;
  logic          last;
  logic          out_fire;

  assign sweep_addr = cnt[AW-1:0];
  assign out_fire   = (state == S_OUT) && (!out_valid || out_ready);

  // End of an iterating phase.
  always_comb begin
    counting = 1'b1;
    last     = 1'b0;
    case (state)
      S_SWEEP_RST, S_CLEAR:    last = (cnt == CW'(MAX_ELEMENTS - 1));
      S_DIVM, S_DIVV, S_DIVS:  last = (cnt == CW'(DIV_STEPS - 1));
      S_SQRT:                  last = (cnt == CW'(SQRT_STEPS - 1));
      default:                 counting = 1'b0;
    endcase
    cnt_next = (counting && !last) ? cnt + 1'b1 : '0;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_SWEEP_RST: if (last) state_next = S_IDLE;
      S_IDLE:      if (item_valid) state_next = S_DECIDE;
      S_DECIDE: begin
        if (status.is_clear)          state_next = S_CLEAR;
        else if (status.out_of_range) state_next = S_OUT;
        else if (status.step_start)   state_next = S_MUL_BFP;
        else                          state_next = S_MUL_M1;
      end
      S_CLEAR:     if (last) state_next = S_OUT;
      S_MUL_BFP:   state_next = S_MUL_BSP;
      S_MUL_BSP:   state_next = S_MUL_M1;
      S_MUL_M1:    state_next = S_MUL_M2;
      S_MUL_M2:    state_next = S_MUL_G2;
      S_MUL_G2:    state_next = S_MUL_V1;
      S_MUL_V1:    state_next = S_MUL_V2;
      S_MUL_V2:    state_next = S_UPD;
      S_UPD:       state_next = S_DIVM_INIT;
      S_DIVM_INIT: state_next = S_DIVM;
      S_DIVM:      if (last) state_next = S_DIVV_INIT;
      S_DIVV_INIT: state_next = S_DIVV;
      S_DIVV:      if (last) state_next = S_SQRT_INIT;
      S_SQRT_INIT: state_next = S_SQRT;
      S_SQRT:      if (last) state_next = S_MUL_STEP;
      S_MUL_STEP:  state_next = S_DIVS_INIT;
      S_DIVS_INIT: state_next = S_DIVS;
      S_DIVS:      if (last) state_next = S_OUT;
      S_OUT:       if (out_fire) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // Datapath command and input handshake.
  always_comb begin
    item_ready = (state == S_IDLE);
    cmd.op     = OP_NONE;
    case (state)
      S_SWEEP_RST, S_CLEAR: cmd.op = OP_SWEEP;
      S_IDLE:      cmd.op = item_valid ? OP_LOAD : OP_NONE;
      S_MUL_BFP:   cmd.op = OP_MUL_BFP;
      S_MUL_BSP:   cmd.op = OP_MUL_BSP;
      S_MUL_M1:    cmd.op = OP_MUL_M1;
      S_MUL_M2:    cmd.op = OP_MUL_M2;
      S_MUL_G2:    cmd.op = OP_MUL_G2;
      S_MUL_V1:    cmd.op = OP_MUL_V1;
      S_MUL_V2:    cmd.op = OP_MUL_V2;
      S_DIVM_INIT: cmd.op = OP_DIVM_INIT;
      S_DIVV_INIT: cmd.op = OP_DIVV_INIT;
      S_DIVM, S_DIVV, S_DIVS: cmd.op = OP_DIV_STEP;
      S_SQRT_INIT: cmd.op = OP_SQRT_INIT;
      S_SQRT:      cmd.op = OP_SQRT_STEP;
      S_MUL_STEP:  cmd.op = OP_MUL_STEP;
      S_DIVS_INIT: cmd.op = OP_DIVS_INIT;
      S_OUT:       cmd.op = out_fire ? OP_OUT : OP_NONE;
      default:     cmd.op = OP_NONE;
    endcase
  end

  // State, step counter and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SWEEP_RST;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_fire || (out_valid && !out_ready);
    end
  end

endmodule

// ----- sv/adam_dp.sv -----
// ----------------------------------------------------------------------------
// Adam optimiser datapath
// Moment stores, beta powers, one shared multiplier, a restoring divider and
// a bit-pair square root unit, all stepped by the controller's commands.
// ----------------------------------------------------------------------------
module adam_dp #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int AW           = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  adam_pkg::cfg_t        cfg,
  input  adam_pkg::dp_cmd_t     cmd,
  input  logic [AW-1:0]         sweep_addr,
  input  logic                  in_op,
  input  logic [9:0]            in_element_index,
  input  logic                  in_step_start,
  input  logic [31:0]           in_gradient,
  input  logic [31:0]           in_param_in,
  output adam_pkg::dp_status_t  status,
  output logic [31:0]           param_out,
  output logic [9:0]            index_out,
  output logic [1:0]            res_status
);
  import adam_pkg::*;

  // Moment stores.
  logic signed [31:0] moment_mem   [MAX_ELEMENTS];
  logic        [31:0] variance_mem [MAX_ELEMENTS];

  // Captured item.
  logic               it_clear;
  logic [9:0]         it_idx;
  logic               it_start;
  logic signed [31:0] it_g;
  logic signed [31:0] it_p;

  logic signed [31:0] rd_m;
  logic [31:0]        rd_v;
  logic [31:0]        bfp, bsp;
  dp_op_t             last_op;

  // Multiplier.
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;
  logic signed [49:0] acc;

  logic signed [31:0] m_new;
  logic [31:0]        g2, v_new, mhat;

  // Divider.
  logic [63:0] div_n, div_d, div_q;
  logic [64:0] div_r, div_t;

  // Square root.
  logic [63:0] sq_x, sq_r, sq_bit, sq_sum;
  logic [48:0] den;

  logic [16:0]        lim, cnt_w, max_w;
  logic               oor;
  logic [31:0]        ag, am;
  logic [16:0]        omb_f, omb_s;
  logic signed [49:0] m_sum;
  logic signed [33:0] m_sh;
  logic [63:0]        g2_sum;
  logic [49:0]        v_sum;
  logic [31:0]        mhat_sat;
  logic [47:0]        vhat_sat;
  logic [32:0]        step_v;
  logic [34:0]        p35, res_w;
  logic [31:0]        res_sat;
  logic [AW-1:0]      it_addr;

  // Range check against min(element_count, MAX_ELEMENTS).
  always_comb begin
    cnt_w = 17'(cfg.element_count);
    max_w = 17'(MAX_ELEMENTS);
    lim   = (cnt_w < max_w) ? cnt_w : max_w;
    oor   = 17'(it_idx) >= lim;
  end

  assign status.is_clear     = it_clear;
  assign status.out_of_range = oor;
  assign status.step_start   = it_start;
  assign it_addr             = AW'(it_idx);

  // Magnitudes and one-minus-beta factors.
  assign ag    = it_g[31] ? 32'(-it_g) : 32'(it_g);
  assign am    = m_new[31] ? 32'(-m_new) : 32'(m_new);
  assign omb_f = 17'h10000 - {1'b0, cfg.beta_first};
  assign omb_s = 17'h10000 - {1'b0, cfg.beta_second};

  // Multiplier operand selection.
  always_comb begin
    case (cmd.op)
      OP_MUL_BFP:  begin ma = {1'b0, bfp};        mb = {17'd0, cfg.beta_first};  end
      OP_MUL_BSP:  begin ma = {1'b0, bsp};        mb = {17'd0, cfg.beta_second}; end
      OP_MUL_M1:   begin ma = {rd_m[31], rd_m};   mb = {17'd0, cfg.beta_first};  end
      OP_MUL_M2:   begin ma = {it_g[31], it_g};   mb = {16'd0, omb_f};           end
      OP_MUL_G2:   begin ma = {1'b0, ag};         mb = {1'b0, ag};               end
      OP_MUL_V1:   begin ma = {1'b0, rd_v};       mb = {17'd0, cfg.beta_second}; end
      OP_MUL_V2:   begin ma = {1'b0, g2};         mb = {16'd0, omb_s};           end
      OP_MUL_STEP: begin ma = {1'b0, cfg.learning_rate}; mb = {1'b0, mhat};      end
      default:     begin ma = '0;                 mb = '0;                       end
    endcase
  end

  // Rounding and saturation of the moment updates.
  always_comb begin
    m_sum  = acc + $signed(prod[49:0]) + 50'sd32768;
    m_sh   = m_sum[49:16];
    g2_sum = prod[63:0] + 64'd32768;
    v_sum  = acc + prod[49:0] + 50'd32768;
  end

  // Divider step: shift in one dividend bit, subtract when it fits.
  assign div_t = {div_r[63:0], div_n[63]};

  // Square root step operand.
  assign sq_sum = sq_r + sq_bit;

  // Quotient saturation.
  assign mhat_sat = (|div_q[63:32]) ? 32'hFFFF_FFFF : div_q[31:0];
  assign vhat_sat = (|div_q[63:48]) ? {48{1'b1}} : div_q[47:0];

  // Final step and parameter update.
  always_comb begin
    if (den == 49'd0)
      step_v = (mhat == 32'd0) ? 33'd0 : 33'h1_0000_0000;
    else if (div_q > 64'h1_0000_0000)
      step_v = 33'h1_0000_0000;
    else
      step_v = div_q[32:0];
    p35   = {{3{it_p[31]}}, it_p};
    res_w = m_new[31] ? p35 + {2'b0, step_v} : p35 - {2'b0, step_v};
    if (res_w[34:31] == 4'b0000 || res_w[34:31] == 4'b1111)
      res_sat = res_w[31:0];
    else
      res_sat = res_w[34] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  end

  // Control-side registers: beta powers and operation history.
  always_ff @(posedge clk) begin
    if (rst) begin
      bfp     <= ONE_Q32;
      bsp     <= ONE_Q32;
      last_op <= OP_NONE;
    end else begin
      last_op <= cmd.op;
      if (cmd.op == OP_SWEEP) begin
        bfp <= ONE_Q32;
        bsp <= ONE_Q32;
      end else if (last_op == OP_MUL_BFP) begin
        bfp <= prod[47:16];
      end else if (last_op == OP_MUL_BSP) begin
        bsp <= prod[47:16];
      end
    end
  end

  // Moment stores: one write port, registered read on item load.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_SWEEP) begin
      moment_mem[sweep_addr]   <= '0;
      variance_mem[sweep_addr] <= '0;
    end else if (cmd.op == OP_DIVM_INIT) begin
      moment_mem[it_addr]   <= m_new;
      variance_mem[it_addr] <= v_new;
    end
    if (cmd.op == OP_LOAD) begin
      rd_m <= moment_mem[AW'(in_element_index)];
      rd_v <= variance_mem[AW'(in_element_index)];
    end
  end

  // Arithmetic registers.
  always_ff @(posedge clk) begin
    prod <= ma * mb;

    // Consume the product of the previous multiply.
    case (last_op)
      OP_MUL_M1, OP_MUL_V1: acc <= $signed(prod[49:0]);
      OP_MUL_M2: begin
        if (m_sh[33:31] == 3'b000 || m_sh[33:31] == 3'b111)
          m_new <= m_sh[31:0];
        else
          m_new <= m_sh[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
      OP_MUL_G2: g2 <= (|g2_sum[63:48]) ? 32'hFFFF_FFFF : g2_sum[47:16];
      OP_MUL_V2: v_new <= (|v_sum[49:48]) ? 32'hFFFF_FFFF : v_sum[47:16];
      default: ;
    endcase

    case (cmd.op)
      OP_LOAD: begin
        it_clear <= (in_op == OPC_CLEAR);
        it_idx   <= in_element_index;
        it_start <= in_step_start;
        it_g     <= in_gradient;
        it_p     <= in_param_in;
      end
      OP_DIVM_INIT: begin
        div_n <= {am, 32'd0};
        div_d <= 64'h1_0000_0000 - {32'd0, bfp};
        div_r <= '0;
        div_q <= '0;
      end
      OP_DIVV_INIT: begin
        mhat  <= mhat_sat;
        div_n <= {v_new, 32'd0};
        div_d <= 64'h1_0000_0000 - {32'd0, bsp};
        div_r <= '0;
        div_q <= '0;
      end
      OP_DIV_STEP: begin
        div_n <= {div_n[62:0], 1'b0};
        if (div_t >= {1'b0, div_d}) begin
          div_r <= div_t - {1'b0, div_d};
          div_q <= {div_q[62:0], 1'b1};
        end else begin
          div_r <= div_t;
          div_q <= {div_q[62:0], 1'b0};
        end
      end
      OP_SQRT_INIT: begin
        sq_x   <= {vhat_sat, 16'd0};
        sq_r   <= '0;
        sq_bit <= 64'h4000_0000_0000_0000;
      end
      OP_SQRT_STEP: begin
        if (sq_x >= sq_sum) begin
          sq_x <= sq_x - sq_sum;
          sq_r <= (sq_r >> 1) + sq_bit;
        end else begin
          sq_r <= sq_r >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
      OP_MUL_STEP: den <= {1'b0, sq_r[31:0], 16'd0} + {17'd0, cfg.stabilizer};
      OP_DIVS_INIT: begin
        div_n <= prod[63:0];
        div_d <= {15'd0, den};
        div_r <= '0;
        div_q <= '0;
      end
      OP_OUT: begin
        index_out <= it_idx;
        if (it_clear) begin
          param_out  <= it_p;
          res_status <= STATUS_CLEARED;
        end else if (oor) begin
          param_out  <= it_p;
          res_status <= STATUS_RANGE;
        end else begin
          param_out  <= res_sat;
          res_status <= STATUS_OK;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- tb/tb_adam_optimizer_update.sv -----
// ----------------------------------------------------------------------------
// Adam optimiser update testbench
// Drives parameter update, clear and out-of-range items through the valid/ready
// item channel with random gaps, and checks every result beat against a
// fixed-point Adam predictor kept in step with the register settings.
// ----------------------------------------------------------------------------
module tb_adam_optimizer_update;
  import adam_pkg::*;

  localparam int NUM_ELEMENTS = 1024;
  localparam int STALL_LIMIT  = 8000;

  typedef struct {
    logic               op;
    logic [9:0]         element_index;
    logic               step_start;
    logic signed [31:0] gradient;
    logic signed [31:0] param_in;
  } update_item_t;

  typedef struct {
    logic [31:0] param_out;
    logic [9:0]  index_out;
    logic [1:0]  status;
  } update_result_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [APB_AW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  adam_item_if   item_ch ();
  adam_result_if res_ch ();

  adam_optimizer_update uut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor copy of the registers and per-element stores.
  logic [15:0] decay_first;
  logic [15:0] decay_second;
  logic [31:0] epsilon_q32;
  logic [31:0] eta_q32;
  logic [10:0] active_count;
  logic signed [31:0] mean_grad [NUM_ELEMENTS];
  logic [31:0] mean_sq_grad [NUM_ELEMENTS];
  logic [31:0] decay_first_pow;
  logic [31:0] decay_second_pow;

  update_item_t   pending_items[$];
  update_result_t expected_params[$];
  update_item_t   offered_item;
  bit             offering;
  bit             item_took;
  bit             hold_items;
  bit             calm;
  int             send_gap;
  int             recv_stall;
  int             mismatch_count;
  int             quiet_cycles;

  // Clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r;
    longint unsigned bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  function automatic void reset_moments();
    for (int i = 0; i < NUM_ELEMENTS; i++) begin
      mean_grad[i] = '0;
      mean_sq_grad[i] = '0;
    end
    decay_first_pow = ONE_Q32;
    decay_second_pow = ONE_Q32;
  endfunction

  // Works out the result of one accepted item and advances the stores.
  function automatic update_result_t adam_step(update_item_t it);
    update_result_t  r;
    int unsigned     lim;
    longint          m;
    longint          g;
    longint          res;
    longint unsigned ag;
    longint unsigned g2;
    longint unsigned v;
    longint unsigned mhat;
    longint unsigned root;
    longint unsigned den;
    logic [95:0]     vhat;
    logic [95:0]     step;
    r.index_out = it.element_index;
    r.param_out = it.param_in;
    lim = (active_count < NUM_ELEMENTS) ? active_count : NUM_ELEMENTS;
    if (it.op == OPC_CLEAR) begin
      reset_moments();
      r.status = STATUS_CLEARED;
      return r;
    end
    if (it.element_index >= lim) begin
      r.status = STATUS_RANGE;
      return r;
    end
    if (it.step_start) begin
      decay_first_pow = 32'((64'(decay_first_pow) * decay_first) >> 16);
      decay_second_pow = 32'((64'(decay_second_pow) * decay_second) >> 16);
    end
    g = longint'(it.gradient);
    m = longint'(decay_first) * longint'(mean_grad[it.element_index])
        + longint'(65536 - int'(decay_first)) * g;
    m = (m + 32768) >>> 16;
    if (m > 64'sd2147483647) m = 64'sd2147483647;
    if (m < -64'sd2147483648) m = -64'sd2147483648;
    mean_grad[it.element_index] = 32'(m);

    ag = (g < 0) ? longint'(-g) : longint'(g);
    g2 = (ag * ag + 32768) >> 16;
    if (g2 > 64'hFFFF_FFFF) g2 = 64'hFFFF_FFFF;
    v = (64'(decay_second) * mean_sq_grad[it.element_index]
         + 64'(65536 - int'(decay_second)) * g2 + 32768) >> 16;
    if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
    mean_sq_grad[it.element_index] = 32'(v);

    mhat = ((m < 0) ? longint'(-m) : longint'(m)) << 32;
    mhat = mhat / (64'h1_0000_0000 - decay_first_pow);
    if (mhat > 64'hFFFF_FFFF) mhat = 64'hFFFF_FFFF;
    vhat = {32'd0, v[31:0], 32'd0} / (96'h1_0000_0000 - decay_second_pow);
    if (vhat > 96'hFFFF_FFFF_FFFF) vhat = 96'hFFFF_FFFF_FFFF;
    root = int_sqrt(64'(vhat) << 16);
    den = (root << 16) + epsilon_q32;

    // A zero denominator gives the saturated step unless there is no mean.
    if (den == 0) step = (mhat == 0) ? 96'd0 : 96'h1_0000_0000;
    else step = (96'(eta_q32) * mhat) / den;
    if (step > 96'h1_0000_0000) step = 96'h1_0000_0000;

    res = (m < 0) ? longint'(it.param_in) + longint'(step)
                  : longint'(it.param_in) - longint'(step);
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    if (res < -64'sd2147483648) res = -64'sd2147483648;
    r.param_out = 32'(res);
    r.status = STATUS_OK;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("ERROR %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Register write: setup beat then access beat; the predictor follows it.
  task automatic apb_write(logic [2:0] reg_idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_AW'({reg_idx, 2'b00});
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (reg_idx)
      REG_BETA_FIRST:    decay_first = value[15:0];
      REG_BETA_SECOND:   decay_second = value[15:0];
      REG_STABILIZER:    epsilon_q32 = value;
      REG_LEARNING_RATE: eta_q32 = value;
      REG_ELEMENT_COUNT: active_count = value[10:0];
      default: ;
    endcase
  endtask

  task automatic push_item(logic op, logic [9:0] idx, logic start,
                           logic [31:0] grad, logic [31:0] param);
    update_item_t it;
    it.op = op;
    it.element_index = idx;
    it.step_start = start;
    it.gradient = grad;
    it.param_in = param;
    pending_items.push_back(it);
  endtask

  // Random item: mostly well-formed update passes over in-range indices.
  task automatic push_random(int unsigned idx_hi);
    logic [31:0] grad;
    logic [9:0]  idx;
    case ($urandom_range(0, 3))
      0: grad = $urandom();
      1: grad = 32'($signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000);
      default: grad = 32'($signed($urandom_range(0, 18'h3FFFF)) - 32'sh20000);
    endcase
    idx = ($urandom_range(0, 9) == 0) ? 10'($urandom()) : 10'($urandom_range(0, idx_hi));
    push_item(($urandom_range(0, 39) == 0) ? OPC_CLEAR : OPC_UPDATE, idx,
              $urandom_range(0, 7) == 0, grad, $urandom());
  endtask

  task automatic drain();
    do begin
      @(posedge clk);
      #1;
    end while (pending_items.size() != 0 || offering || expected_params.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  // Item driver: one beat offered at a time, random gaps between beats.
  always @(negedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
      send_gap = 0;
    end else if (!offering) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_items.size() != 0 && !hold_items) begin
        offered_item = pending_items.pop_front();
        offering = 1;
        item_ch.valid <= 1'b1;
        item_ch.op <= offered_item.op;
        item_ch.element_index <= offered_item.element_index;
        item_ch.step_start <= offered_item.step_start;
        item_ch.gradient <= offered_item.gradient;
        item_ch.param_in <= offered_item.param_in;
        if (!calm && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 4);
      end
    end else if (item_took) begin
      item_ch.valid <= 1'b0;
      offering = 0;
    end
  end

  // Result ready with random stall bursts.
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      recv_stall = 0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      res_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      recv_stall = $urandom_range(0, 3);
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // Monitor: predicts accepted items, checks result beats, watches for hangs.
  always @(posedge clk) begin
    update_result_t want;
    item_took = 0;
    if (!rst) begin
      quiet_cycles++;
      if (item_ch.valid && item_ch.ready) begin
        item_took = 1;
        quiet_cycles = 0;
        expected_params.push_back(adam_step(offered_item));
      end
      if (res_ch.valid && res_ch.ready) begin
        quiet_cycles = 0;
        if (expected_params.size() == 0) begin
          report_mismatch("unexpected result beat, param_out", res_ch.param_out, '0);
        end else begin
          want = expected_params.pop_front();
          if (res_ch.param_out !== want.param_out)
            report_mismatch("param_out", res_ch.param_out, want.param_out);
          if (res_ch.index_out !== want.index_out)
            report_mismatch("index_out", 32'(res_ch.index_out), 32'(want.index_out));
          if (res_ch.status !== want.status)
            report_mismatch("status", 32'(res_ch.status), 32'(want.status));
        end
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Stimulus phases.
  initial begin
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    item_ch.valid = 1'b0;
    item_ch.op = OPC_UPDATE;
    item_ch.element_index = '0;
    item_ch.step_start = 1'b0;
    item_ch.gradient = '0;
    item_ch.param_in = '0;
    res_ch.ready = 1'b0;
    offering = 0;
    hold_items = 0;
    calm = 0;
    mismatch_count = 0;
    quiet_cycles = 0;
    decay_first = BETA_FIRST_RST;
    decay_second = BETA_SECOND_RST;
    epsilon_q32 = STABILIZER_RST;
    eta_q32 = LEARNING_RATE_RST;
    active_count = ELEMENT_COUNT_RST;
    reset_moments();
    rst = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: field extremes, step start, last index, clear.
    push_item(OPC_UPDATE, 10'd0, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_item(OPC_UPDATE, 10'd0, 1'b0, 32'h8000_0000, 32'h8000_0000);
    push_item(OPC_UPDATE, 10'd1023, 1'b0, 32'h0001_0000, 32'h0000_0000);
    push_item(OPC_UPDATE, 10'd1023, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF);
    push_item(OPC_UPDATE, 10'd512, 1'b0, 32'hFFFF_0000, 32'h8000_0000);
    push_item(OPC_UPDATE, 10'd341, 1'b0, 32'h0000_0001, 32'h7FFF_FFFF);
    push_item(OPC_CLEAR, 10'd682, 1'b1, 32'h7FFF_FFFF, 32'h1234_5678);
    push_item(OPC_UPDATE, 10'd0, 1'b1, 32'hFFFF_FFFF, 32'h0000_0001);
    for (int i = 0; i < 150; i++) begin
      push_random(1023);
      if (i == 70) begin
        // Wait until every expected result has come back, then hold a queued item back before releasing it.
        drain();
        hold_items = 1;
        push_random(1023);
        repeat (30) @(posedge clk);
        hold_items = 0;
        drain();
      end
    end
    drain();

    // Extreme settings: zero decay, zero epsilon, full learning rate.
    apb_write(REG_BETA_FIRST, 32'd0);
    apb_write(REG_BETA_SECOND, 32'd0);
    apb_write(REG_STABILIZER, 32'd0);
    apb_write(REG_LEARNING_RATE, 32'hFFFF_FFFF);
    apb_write(REG_ELEMENT_COUNT, 32'h7FF);
    // Zero denominator with and without a mean, then an ignored register.
    push_item(OPC_UPDATE, 10'd3, 1'b1, 32'h0000_0001, 32'h0000_0000);
    push_item(OPC_UPDATE, 10'd4, 1'b0, 32'h0000_0000, 32'h0000_0100);
    push_item(OPC_UPDATE, 10'd5, 1'b0, 32'hFFFF_FFFF, 32'h8000_0000);
    for (int i = 0; i < 60; i++) push_random(15);
    drain();
    apb_write(3'd5, 32'h0000_0003);

    // Other extremes; an element count of zero flags every index.
    apb_write(REG_BETA_FIRST, 32'hFFFF);
    apb_write(REG_BETA_SECOND, 32'hFFFF);
    apb_write(REG_STABILIZER, 32'hFFFF_FFFF);
    apb_write(REG_LEARNING_RATE, 32'd0);
    apb_write(REG_ELEMENT_COUNT, 32'd0);
    push_item(OPC_UPDATE, 10'd0, 1'b1, 32'h0001_0000, 32'h0000_2000);
    push_item(OPC_UPDATE, 10'd1023, 1'b0, 32'h0001_0000, 32'h0000_2000);
    drain();
    apb_write(REG_ELEMENT_COUNT, 32'd37);
    apb_write(REG_LEARNING_RATE, 32'h4000_0000);
    push_item(OPC_UPDATE, 10'd36, 1'b1, 32'h0100_0000, 32'h0);
    push_item(OPC_UPDATE, 10'd37, 1'b0, 32'h0100_0000, 32'h0);
    for (int i = 0; i < 70; i++) push_random(45);
    drain();

    // Middling settings; the last batch runs with no idling on either side.
    apb_write(REG_BETA_FIRST, $urandom_range(30000, 65000));
    apb_write(REG_BETA_SECOND, $urandom_range(30000, 65000));
    apb_write(REG_STABILIZER, $urandom_range(1, 1000000));
    apb_write(REG_LEARNING_RATE, $urandom());
    apb_write(REG_ELEMENT_COUNT, 32'd1);
    push_item(OPC_UPDATE, 10'd0, 1'b1, 32'h0002_0000, 32'h0001_0000);
    push_item(OPC_UPDATE, 10'd1, 1'b0, 32'h0002_0000, 32'h0001_0000);
    drain();
    apb_write(REG_ELEMENT_COUNT, 32'd1024);
    calm = 1;
    for (int i = 0; i < 110; i++) push_random(1023);
    drain();
    repeat (300) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
